>>> rtl/sha1md_pkg.sv
// Shared types and constants for the streaming SHA-1 digest block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package sha1md_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 80;
    localparam int DIGEST_WORDS = 5;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      shift_byte;
        byte_sel_t byte_sel;
        logic      count_msg;
        logic      start;
        logic      round;
        logic      add;
        logic      out_adv;
        logic      clear;
    } cmd_t;

    typedef struct packed {
        logic pos_full;
        logic pos_at56;
        logic round_last;
        logic out_last;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/sha1md_ctrl.sv
// Sequencer for the SHA-1 block: byte intake, padding, compression and readout.
// Depends on sha1md_pkg; drives the datapath through cmd_t, watches status_t.
`default_nettype none

module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    in_has,
    input  wire logic    in_last,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_has && status.pos_full)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = in_last ? ST_MARK : ST_IDLE;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_ROUND:
            begin
                if (status.round_last)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ret_reg;
            end
            ST_MARK:
            begin
                if (status.pos_full)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_ZERO;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (status.pos_at56)
                begin
                    state_next = ST_LEN;
                end
                else if (status.pos_full)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_ZERO;
                end
            end
            ST_LEN:
            begin
                // the eighth length byte always closes the block
                if (status.pos_full)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready && status.out_last)
                begin
                    state_next = ST_IDLE;
                    ret_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        cmd.byte_sel = BSEL_DATA;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_has)
                begin
                    cmd.shift_byte = 1'b1;
                    cmd.count_msg  = 1'b1;
                    cmd.start      = status.pos_full;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
            end
            ST_MARK:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = BSEL_MARK;
                cmd.start      = status.pos_full;
            end
            ST_ZERO:
            begin
                if (!status.pos_at56)
                begin
                    cmd.shift_byte = 1'b1;
                    cmd.byte_sel   = BSEL_ZERO;
                    cmd.start      = status.pos_full;
                end
            end
            ST_LEN:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = BSEL_LEN;
                cmd.start      = status.pos_full;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.out_adv = 1'b1;
                    cmd.clear   = status.out_last;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_start_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == ST_ROUND)
        else $error("block start did not enter rounds");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("intake open while digest is being read out");

    a_add_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> $past(state_reg) == ST_ROUND)
        else $error("chaining add without preceding rounds");
`endif

endmodule

`default_nettype wire

>>> rtl/sha1md_datapath.sv
// SHA-1 datapath: schedule shift line, round registers, chaining words,
// byte position, message length and digest readout. Depends on sha1md_pkg.
`default_nettype none

module sha1md_datapath
    import sha1md_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    input  wire logic [7:0] data_byte,
    output status_t         status,
    output logic [31:0]     digest_word,
    output logic [2:0]      word_index,
    output logic            last_word
);

    // w[0] sits in the top word; bytes enter at the bottom
    logic [511:0]         win_reg, win_next;
    logic [4:0][31:0]     work_reg, work_next;
    logic [4:0][31:0]     chain_reg, chain_next;
    logic [5:0]           pos_reg, pos_next;
    logic [60:0]          msg_reg, msg_next;
    logic [6:0]           round_reg, round_next;
    logic [2:0]           len_idx_reg, len_idx_next;
    logic [2:0]           out_idx_reg, out_idx_next;

    logic [63:0] len_bits;
    logic [7:0]  byte_in;
    logic [31:0] w0, w2, w8, w13, w_new;
    logic [31:0] a, b, c, d, e, f, k, t;

    assign len_bits = {msg_reg, 3'b000};
    assign w0  = win_reg[511:480];
    assign w2  = win_reg[447:416];
    assign w8  = win_reg[255:224];
    assign w13 = win_reg[95:64];
    assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                    w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

    assign a = work_reg[0];
    assign b = work_reg[1];
    assign c = work_reg[2];
    assign d = work_reg[3];
    assign e = work_reg[4];

    always_comb
    begin
        unique case (cmd.byte_sel)
            BSEL_DATA: byte_in = data_byte;
            BSEL_MARK: byte_in = PAD_MARK;
            BSEL_ZERO: byte_in = 8'h00;
            BSEL_LEN:  byte_in = len_bits[{~len_idx_reg, 3'b000} +: 8];
            default:   byte_in = 8'h00;
        endcase
    end

    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f = (b & c) | (~b & d);
            k = K0;
        end
        else if (round_reg < 7'd40)
        begin
            f = b ^ c ^ d;
            k = K1;
        end
        else if (round_reg < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
        end
        else
        begin
            f = b ^ c ^ d;
            k = K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w0;
    end

    always_comb
    begin
        win_next     = win_reg;
        work_next    = work_reg;
        chain_next   = chain_reg;
        pos_next     = pos_reg;
        msg_next     = msg_reg;
        round_next   = round_reg;
        len_idx_next = len_idx_reg;
        out_idx_next = out_idx_reg;

        if (cmd.shift_byte)
        begin
            win_next = {win_reg[503:0], byte_in};
            pos_next = pos_reg + 6'd1;
            if (cmd.byte_sel == BSEL_LEN)
                len_idx_next = len_idx_reg + 3'd1;
        end
        if (cmd.count_msg)
            msg_next = msg_reg + 61'd1;
        if (cmd.start)
        begin
            work_next  = chain_reg;
            round_next = '0;
        end
        if (cmd.round)
        begin
            win_next   = {win_reg[479:0], w_new};
            work_next  = {d, c, {b[1:0], b[31:2]}, a, t};
            round_next = round_reg + 7'd1;
        end
        if (cmd.add)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain_next[i] = chain_reg[i] + work_reg[i];
        end
        if (cmd.out_adv)
            out_idx_next = status.out_last ? 3'd0 : out_idx_reg + 3'd1;
        if (cmd.clear)
        begin
            chain_next   = {IV4, IV3, IV2, IV1, IV0};
            pos_next     = '0;
            msg_next     = '0;
            len_idx_next = '0;
            out_idx_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg   <= {IV4, IV3, IV2, IV1, IV0};
            pos_reg     <= '0;
            msg_reg     <= '0;
            round_reg   <= '0;
            len_idx_reg <= '0;
            out_idx_reg <= '0;
        end
        else
        begin
            chain_reg   <= chain_next;
            pos_reg     <= pos_next;
            msg_reg     <= msg_next;
            round_reg   <= round_next;
            len_idx_reg <= len_idx_next;
            out_idx_reg <= out_idx_next;
        end
    end

    assign status.pos_full   = (pos_reg == 6'(BLOCK_BYTES - 1));
    assign status.pos_at56   = (pos_reg == 6'd56);
    assign status.round_last = (round_reg == 7'(ROUNDS - 1));
    assign status.out_last   = (out_idx_reg == 3'(DIGEST_WORDS - 1));

    assign digest_word = chain_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = status.out_last;

`ifndef NO_ASSERTIONS
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= 7'(ROUNDS))
        else $error("round counter out of range");

    a_start_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (cmd.shift_byte && pos_reg == 6'(BLOCK_BYTES - 1)))
        else $error("compression started on a partial block");

    a_len_place: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift_byte && cmd.byte_sel == BSEL_LEN) |-> pos_reg[5:3] == 3'b111)
        else $error("length byte outside the last eight block positions");
`endif

endmodule

`default_nettype wire

>>> rtl/sha1_message_digest.sv
// Streaming SHA-1 digest, top level: joins the sequencer and the datapath.
// Depends on sha1md_pkg, sha1md_ctrl and sha1md_datapath.
//
// Usage:
//   s_axis carries message bytes: tdata[7:0] is the byte, tuser[0] says the
//   byte is present, tlast ends the message. A request with tuser[0] low and
//   tlast high ends the message with no byte; one with both low is a no-op.
//   m_axis returns five words per message: tdata is the digest word, tuser the
//   word index (0 = h0 .. 4 = h4), tlast marks h4.
// Timing:
//   Bytes are taken one per cycle while intake is open. The byte that fills a
//   64-byte block starts the 80 rounds on one shared round unit, then the
//   chaining add; intake stays closed until the add is done.
//   After the last request the pad of 9 to 72 bytes is shifted in byte by byte,
//   with one or two further compressions, then the digest follows.
// Reset puts the chaining words at the SHA-1 initial values with intake open.
// While m_axis_tready is low the current word holds and no new request is
// taken; after h4 is taken the block is ready for the next message.
`default_nettype none

module sha1_message_digest
    import sha1md_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast
);

    cmd_t    cmd;
    status_t status;

    sha1md_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_has    (s_axis_tuser[0]),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    sha1md_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (s_axis_tdata),
        .status      (status),
        .digest_word (m_axis_tdata),
        .word_index  (m_axis_tuser),
        .last_word   (m_axis_tlast)
    );

endmodule

`default_nettype wire
